FILE: rtl/bfdc_pkg.sv
// Package for the boundary fractal dimension counter.
// Holds shared widths, item kind codes and default parameters; no dependencies.
`timescale 1ns / 1ps

package bfdc_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int SCALES_DEF    = 8;

    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam int COORD_W = 8;
    localparam int LEVEL_W = 3;
    localparam int BOX_W   = 17;
    localparam int DIV_W   = 16;
    localparam int REM_W   = 17;

    localparam logic [BOX_W-1:0] BOX_MAX = {BOX_W{1'b1}};
    localparam logic [DIV_W-1:0] DIV_MAX = {DIV_W{1'b1}};

endpackage

FILE: rtl/boundary_fractal_dimension_counter.sv
// Top level of the boundary fractal dimension counter.
// Uses bfdc_pkg for codes and widths; holds the mark bitmap as a one-bit synchronous memory.
`timescale 1ns / 1ps

// After reset the bitmap is cleared one cell per cycle before the first beat is accepted. Point
// items and ignored items leave the block idle. A begin item starts the sweep that clears the
// bitmap, and no beat is accepted until it ends. A finish item reads the bitmap once in Z order,
// one cell per cycle, so that every box of every scale is a contiguous run of reads; the last
// read then drains through the read register. Results leave one beat per scale, level 0 first,
// and a finish item holds off the next input until the last result beat is taken.
module boundary_fractal_dimension_counter #(
    parameter int SCALES = bfdc_pkg::SCALES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pos_x[7:0], pos_y[15:8], do_mark[16], do_measure[17], zero fill [23:18]
    input  logic [23:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: level[2:0], boxes[19:3], divider_count[35:20], remaining_sq[52:36], zeros
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int GRID_SIDE = bfdc_pkg::GRID_SIDE_DEF;
    localparam int AW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int MA_W  = 2 * AW;
    localparam int LV_W  = (SCALES > 1) ? $clog2(SCALES) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [2:0] ADDR_OFFX = 3'd0;
    localparam logic [2:0] ADDR_OFFY = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [7:0] offset_x_reg, offset_y_reg;

    logic mark_mem [CELLS];
    logic mem_rd_reg;
    logic [MA_W-1:0] mem_wa, mem_ra;
    logic mem_we, mem_wd;

    logic [MA_W-1:0] sweep_reg;
    logic [MA_W-1:0] rd_addr_reg;
    logic rd_valid_reg;

    logic [7:0] start_x_reg, start_y_reg;
    logic [7:0] last_x_reg [SCALES];
    logic [7:0] last_y_reg [SCALES];
    logic [bfdc_pkg::DIV_W-1:0] div_cnt_reg [SCALES];

    // One flag per scale: the current box has held a mark so far.
    logic [SCALES-1:0] occ_reg;
    logic [bfdc_pkg::BOX_W-1:0] box_cnt_reg [SCALES];

    logic [LV_W-1:0] lvl_reg;

    logic [1:0] in_kind;
    logic [7:0] in_x, in_y;
    logic in_mark, in_meas;
    logic s_acc;

    assign in_kind = s_tuser;
    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_mark = s_tdata[16];
    assign in_meas = s_tdata[17];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;

    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr)
            ADDR_OFFX: prdata = {24'd0, offset_x_reg};
            ADDR_OFFY: prdata = {24'd0, offset_y_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= 8'd0;
            offset_y_reg <= 8'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_OFFX) offset_x_reg <= pwdata[7:0];
            if (paddr == ADDR_OFFY) offset_y_reg <= pwdata[7:0];
        end
    end

    logic [8:0] sx, sy;
    logic [AW-1:0] cx, cy;
    assign sx = {1'b0, in_x} + {1'b0, offset_x_reg};
    assign sy = {1'b0, in_y} + {1'b0, offset_y_reg};
    assign cx = sx[AW-1:0];
    assign cy = sy[AW-1:0];

    always_comb
    begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wa = sweep_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (s_acc && in_kind == bfdc_pkg::KIND_POINT && in_mark)
        begin
            mem_we = 1'b1;
            mem_wd = 1'b1;
            mem_wa = {cy, cx};
        end
    end

    // The sweep index is read in Z order: even bits give the column, odd bits the row.
    always_comb
    begin
        for (int j = 0; j < AW; j++)
        begin
            mem_ra[j]      = sweep_reg[2 * j];
            mem_ra[AW + j] = sweep_reg[2 * j + 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mark_mem[mem_wa] <= mem_wd;
        mem_rd_reg <= mark_mem[mem_ra];
    end

    function automatic logic [bfdc_pkg::REM_W-1:0] sqd(input logic [7:0] ax, input logic [7:0] ay,
                                                       input logic [7:0] bx, input logic [7:0] by);
        logic [7:0] dx, dy;
        logic [15:0] px, py;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        px = dx * dx;
        py = dy * dy;
        return {1'b0, px} + {1'b0, py};
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (sweep_reg == MA_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (s_acc && in_kind == bfdc_pkg::KIND_BEGIN) state_next = ST_CLEAR;
                else if (s_acc && in_kind == bfdc_pkg::KIND_FINISH) state_next = ST_SCAN;
            end
            ST_SCAN:  if (sweep_reg == MA_W'(CELLS - 1)) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_valid_reg) state_next = ST_EMIT;
            ST_EMIT:  if (m_tready && lvl_reg == LV_W'(SCALES - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            start_x_reg  <= 8'd0;
            start_y_reg  <= 8'd0;
            lvl_reg      <= '0;
            occ_reg      <= '0;
            for (int i = 0; i < SCALES; i++)
            begin
                last_x_reg[i]  <= 8'd0;
                last_y_reg[i]  <= 8'd0;
                div_cnt_reg[i] <= '0;
                box_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN);
            rd_addr_reg  <= sweep_reg;
            unique case (state_reg)
                ST_CLEAR: sweep_reg <= sweep_reg + 1'b1;
                ST_IDLE:
                begin
                    sweep_reg <= '0;
                    lvl_reg <= '0;
                    if (s_acc && in_kind == bfdc_pkg::KIND_BEGIN)
                    begin
                        start_x_reg <= in_x;
                        start_y_reg <= in_y;
                        for (int i = 0; i < SCALES; i++)
                        begin
                            last_x_reg[i]  <= in_x;
                            last_y_reg[i]  <= in_y;
                            div_cnt_reg[i] <= '0;
                        end
                    end
                    else if (s_acc && in_kind == bfdc_pkg::KIND_POINT && in_meas)
                    begin
                        for (int i = 0; i < SCALES; i++)
                        begin
                            if ({7'd0, sqd(last_x_reg[i], last_y_reg[i], in_x, in_y)}
                                >= (24'd1 << (2 * i)))
                            begin
                                if (div_cnt_reg[i] != bfdc_pkg::DIV_MAX)
                                    div_cnt_reg[i] <= div_cnt_reg[i] + 1'b1;
                                last_x_reg[i] <= in_x;
                                last_y_reg[i] <= in_y;
                            end
                        end
                    end
                    else if (s_acc && in_kind == bfdc_pkg::KIND_FINISH)
                    begin
                        occ_reg <= '0;
                        for (int i = 0; i < SCALES; i++)
                        begin
                            box_cnt_reg[i] <= '0;
                        end
                    end
                end
                ST_SCAN: sweep_reg <= sweep_reg + 1'b1;
                ST_EMIT:
                begin
                    if (m_tready) lvl_reg <= lvl_reg + 1'b1;
                end
                default: ;
            endcase

            // A box of side 2^i is a run of 4^i reads; it is counted on the run's last read.
            if (rd_valid_reg)
            begin
                for (int i = 0; i < SCALES; i++)
                begin
                    logic [MA_W-1:0] run_mask;
                    logic box_end, box_hit;
                    run_mask = (2 * i >= MA_W) ? '1 : MA_W'((1 << (2 * i)) - 1);
                    box_end  = ((rd_addr_reg & run_mask) == run_mask);
                    box_hit  = occ_reg[i] || mem_rd_reg;
                    if (box_end && box_hit && box_cnt_reg[i] != bfdc_pkg::BOX_MAX)
                        box_cnt_reg[i] <= box_cnt_reg[i] + 1'b1;
                    occ_reg[i] <= box_hit && !box_end;
                end
            end
        end
    end

    logic [bfdc_pkg::REM_W-1:0] rem_now;
    assign rem_now = sqd(last_x_reg[lvl_reg], last_y_reg[lvl_reg], start_x_reg, start_y_reg);

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (lvl_reg == LV_W'(SCALES - 1));
    assign m_tdata  = {3'd0, rem_now, div_cnt_reg[lvl_reg], box_cnt_reg[lvl_reg],
                       bfdc_pkg::LEVEL_W'(lvl_reg)};

endmodule
